/* design/nlp_pkg.sv */
// Shared types, character codes and classification functions for the numeric literal parser.
package nlp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int LINE_CHARS_DEF = 1024;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int OUT_VALUE_W    = 32;
    localparam int CONSUMED_W     = 11;
    localparam int OUT_DATA_W     = 48;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_CONST = 2'd1,
        ST_BAD_DIGIT = 2'd2,
        ST_SYNTAX    = 2'd3
    } status_t;

    localparam digit_t DIGIT_CLIP = 6'd62;
    localparam digit_t MAX_FOLDED = 6'd36;

    localparam char_t CH_BLANK_MAX = 8'd32;
    localparam char_t CH_HASH      = 8'h23;
    localparam char_t CH_DOLLAR    = 8'h24;
    localparam char_t CH_PERCENT   = 8'h25;
    localparam char_t CH_ZERO      = 8'h30;
    localparam char_t CH_NINE      = 8'h39;
    localparam char_t CH_UP_A      = 8'h41;
    localparam char_t CH_UP_Z      = 8'h5A;
    localparam char_t CH_LO_A      = 8'h61;
    localparam char_t CH_LO_Z      = 8'h7A;
    localparam char_t CH_UP_X      = 8'h58;
    localparam char_t CH_LO_X      = 8'h78;

    typedef struct packed {
        logic [CONSUMED_W-1:0]  consumed;
        logic                   overflow;
        logic [OUT_VALUE_W-1:0] value;
        status_t                status;
    } result_t;

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input char_t c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic logic is_alnum(input char_t c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic digit_t digit_of(input char_t c);
        digit_t d;
        if (is_digit(c))
            d = DIGIT_W'(c - CH_ZERO);
        else if ((c >= CH_UP_A) && (c <= CH_UP_Z))
            d = DIGIT_W'(c - CH_UP_A + 8'd10);
        else if ((c >= CH_LO_A) && (c <= CH_LO_Z))
            d = DIGIT_W'(c - CH_LO_A + 8'd10);
        else
            d = DIGIT_CLIP;
        return d;
    endfunction

endpackage

/* design/numeric_literal_parser_top.sv */
// Top level of the numeric literal parser: input word register and stream ports.
// The terminating character passes through the input register, and its result word is then held in the result register.
// Throughput: one character per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset: asynchronous, active low; clears the scan to idle, the accumulators and both
// valid flags.
module numeric_literal_parser_top #(
    parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEF,
    parameter int LINE_CHARS = nlp_pkg::LINE_CHARS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nlp_pkg::CHAR_W-1:0]     s_tdata,  // [7:0] char_code
    input  logic                           s_tuser,  // [0] start_req
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nlp_pkg::OUT_DATA_W-1:0] m_tdata   // [1:0] status, [33:2] value,
                                                     // [34] overflow, [45:35] consumed
);
    import nlp_pkg::*;

    logic    in_valid_reg;
    char_t   char_reg;
    logic    start_reg;
    logic    advance;
    logic    out_valid;
    result_t result;

    assign advance  = !out_valid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    nlp_core #(
        .VALUE_BITS(VALUE_BITS),
        .LINE_CHARS(LINE_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .char_code (char_reg),
        .start_req (start_reg),
        .advance   (advance),
        .out_valid (out_valid),
        .result    (result)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_DATA_W'(result);

endmodule

/* design/nlp_fold.sv */
// One accumulator step acc*RADIX + digit with signed wrap detection.
module nlp_fold #(
    parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEF,
    parameter int RADIX      = 10
) (
    input  logic [VALUE_BITS-1:0] acc,
    input  nlp_pkg::digit_t       digit,
    output logic [VALUE_BITS-1:0] acc_new,
    output logic                  wrapped
);
    import nlp_pkg::*;

    assign acc_new = VALUE_BITS'(acc * VALUE_BITS'(RADIX)) + VALUE_BITS'(digit);
    assign wrapped = $signed(acc_new) < $signed(acc);

endmodule

/* design/nlp_core.sv */
// Scan state machine, radix accumulators and result register.
module nlp_core #(
    parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEF,
    parameter int LINE_CHARS = nlp_pkg::LINE_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  nlp_pkg::char_t   char_code,
    input  logic             start_req,
    input  logic             advance,
    output logic             out_valid,
    output nlp_pkg::result_t result
);
    import nlp_pkg::*;

    localparam int CNT_W = $clog2(LINE_CHARS + 1);

    typedef logic [VALUE_BITS-1:0] acc_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BLANK,
        M_HEXPRE,
        M_HEXRUN,
        M_BINPRE,
        M_BINRUN,
        M_ZERO,
        M_SUFFIX
    } mode_t;

    mode_t   mode_reg, mode_next, mode_eff;
    acc_t    bin_reg, oct_reg, dec_reg, hex_reg;
    acc_t    bin_next, oct_next, dec_next, hex_next;
    acc_t    bin_eff, oct_eff, dec_eff, hex_eff;
    acc_t    bin_fold, oct_fold, dec_fold, hex_fold;
    logic    bin_wrap, oct_wrap, dec_wrap, hex_wrap;
    logic [3:0] wrap_reg, wrap_next, wrap_eff, wrap_fold;
    digit_t  max_reg, max_next, max_eff, max_fold;
    char_t   held_reg, held_next, held_eff;
    count_t  count_reg, count_next, count_eff, count_bump;
    digit_t  cur_digit, held_digit, held_digit_p1, fold_digit;
    logic    emit;
    status_t status;
    acc_t    emit_value;
    logic    emit_ovf;
    logic    out_valid_reg;
    result_t result_reg, result_next;
    logic    step;
    logic    suffix_mode;

    assign step = in_valid && advance;

    assign mode_eff  = start_req ? M_BLANK : mode_reg;
    assign bin_eff   = start_req ? '0 : bin_reg;
    assign oct_eff   = start_req ? '0 : oct_reg;
    assign dec_eff   = start_req ? '0 : dec_reg;
    assign hex_eff   = start_req ? '0 : hex_reg;
    assign wrap_eff  = start_req ? '0 : wrap_reg;
    assign max_eff   = start_req ? '0 : max_reg;
    assign held_eff  = start_req ? '0 : held_reg;
    assign count_eff = start_req ? '0 : count_reg;

    assign cur_digit     = digit_of(char_code);
    assign held_digit    = digit_of(held_eff);
    assign held_digit_p1 = held_digit + 6'd1;
    assign suffix_mode   = (mode_eff == M_ZERO) || (mode_eff == M_SUFFIX);
    assign fold_digit    = suffix_mode ? held_digit : cur_digit;
    assign max_fold      = (held_digit_p1 > max_eff) ? held_digit_p1 : max_eff;
    assign wrap_fold     = wrap_eff | {hex_wrap, dec_wrap, oct_wrap, bin_wrap};
    assign count_bump    = (count_eff < CNT_W'(LINE_CHARS)) ? count_eff + CNT_W'(1) : count_eff;

    nlp_fold #(.VALUE_BITS(VALUE_BITS), .RADIX(2)) u_fold_bin (
        .acc(bin_eff), .digit(fold_digit), .acc_new(bin_fold), .wrapped(bin_wrap)
    );
    nlp_fold #(.VALUE_BITS(VALUE_BITS), .RADIX(8)) u_fold_oct (
        .acc(oct_eff), .digit(fold_digit), .acc_new(oct_fold), .wrapped(oct_wrap)
    );
    nlp_fold #(.VALUE_BITS(VALUE_BITS), .RADIX(10)) u_fold_dec (
        .acc(dec_eff), .digit(fold_digit), .acc_new(dec_fold), .wrapped(dec_wrap)
    );
    nlp_fold #(.VALUE_BITS(VALUE_BITS), .RADIX(16)) u_fold_hex (
        .acc(hex_eff), .digit(fold_digit), .acc_new(hex_fold), .wrapped(hex_wrap)
    );

    always_comb
    begin
        mode_next  = mode_eff;
        bin_next   = bin_eff;
        oct_next   = oct_eff;
        dec_next   = dec_eff;
        hex_next   = hex_eff;
        wrap_next  = wrap_eff;
        max_next   = max_eff;
        held_next  = held_eff;
        count_next = count_eff;
        emit       = 1'b0;
        status     = ST_OK;
        emit_value = '0;
        emit_ovf   = 1'b0;
        case (mode_eff)
            M_BLANK:
            begin
                if ((char_code >= 8'd1) && (char_code <= CH_BLANK_MAX))
                    count_next = count_bump;
                else if ((char_code == CH_HASH) || (char_code == CH_DOLLAR))
                begin
                    count_next = count_bump;
                    mode_next  = M_HEXPRE;
                end
                else if (char_code == CH_PERCENT)
                begin
                    count_next = count_bump;
                    mode_next  = M_BINPRE;
                end
                else if (is_alnum(char_code))
                begin
                    count_next = count_bump;
                    held_next  = char_code;
                    mode_next  = (char_code == CH_ZERO) ? M_ZERO : M_SUFFIX;
                end
                else
                begin
                    emit   = 1'b1;
                    status = ST_NOT_CONST;
                end
            end
            M_HEXPRE, M_HEXRUN:
            begin
                if (is_alnum(char_code))
                begin
                    if (cur_digit >= 6'd16)
                    begin
                        emit   = 1'b1;
                        status = ST_BAD_DIGIT;
                    end
                    else
                    begin
                        hex_next   = hex_fold;
                        wrap_next  = wrap_eff | {hex_wrap, 3'b000};
                        count_next = count_bump;
                        mode_next  = M_HEXRUN;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    status     = (mode_eff == M_HEXPRE) ? ST_SYNTAX : ST_OK;
                    emit_value = hex_eff;
                    emit_ovf   = wrap_eff[3];
                end
            end
            M_BINPRE, M_BINRUN:
            begin
                if (is_digit(char_code))
                begin
                    if (cur_digit >= 6'd2)
                    begin
                        emit   = 1'b1;
                        status = ST_BAD_DIGIT;
                    end
                    else
                    begin
                        bin_next   = bin_fold;
                        wrap_next  = wrap_eff | {3'b000, bin_wrap};
                        count_next = count_bump;
                        mode_next  = M_BINRUN;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    status     = (mode_eff == M_BINPRE) ? ST_SYNTAX : ST_OK;
                    emit_value = bin_eff;
                    emit_ovf   = wrap_eff[0];
                end
            end
            M_ZERO, M_SUFFIX:
            begin
                if ((mode_eff == M_ZERO) && ((char_code == CH_LO_X) || (char_code == CH_UP_X)))
                begin
                    count_next = count_bump;
                    mode_next  = M_HEXPRE;
                end
                else if (is_alnum(char_code))
                begin
                    bin_next   = bin_fold;
                    oct_next   = oct_fold;
                    dec_next   = dec_fold;
                    hex_next   = hex_fold;
                    wrap_next  = wrap_fold;
                    max_next   = max_fold;
                    held_next  = char_code;
                    count_next = count_bump;
                    mode_next  = M_SUFFIX;
                end
                else
                begin
                    emit = 1'b1;
                    if (is_digit(held_eff))
                    begin
                        status     = (max_fold > 6'd10) ? ST_BAD_DIGIT : ST_OK;
                        emit_value = dec_fold;
                        emit_ovf   = wrap_fold[2];
                    end
                    else if (max_eff == '0)
                        status = ST_NOT_CONST;
                    else if (held_eff inside {"b", "B"})
                    begin
                        status     = (max_eff > 6'd2) ? ST_BAD_DIGIT : ST_OK;
                        emit_value = bin_eff;
                        emit_ovf   = wrap_eff[0];
                    end
                    else if (held_eff inside {"o", "O", "q", "Q"})
                    begin
                        status     = (max_eff > 6'd8) ? ST_BAD_DIGIT : ST_OK;
                        emit_value = oct_eff;
                        emit_ovf   = wrap_eff[1];
                    end
                    else if (held_eff inside {"d", "D"})
                    begin
                        status     = (max_eff > 6'd10) ? ST_BAD_DIGIT : ST_OK;
                        emit_value = dec_eff;
                        emit_ovf   = wrap_eff[2];
                    end
                    else if (held_eff inside {"h", "H"})
                    begin
                        status     = (max_eff > 6'd16) ? ST_BAD_DIGIT : ST_OK;
                        emit_value = hex_eff;
                        emit_ovf   = wrap_eff[3];
                    end
                    else
                        status = ST_NOT_CONST;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
        if (emit)
            mode_next = M_IDLE;
        result_next.status   = status;
        result_next.value    = (status == ST_OK) ? OUT_VALUE_W'(emit_value) : '0;
        result_next.overflow = (status == ST_OK) ? emit_ovf : 1'b0;
        result_next.consumed = (status == ST_OK) ? CONSUMED_W'(count_eff) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            bin_reg       <= '0;
            oct_reg       <= '0;
            dec_reg       <= '0;
            hex_reg       <= '0;
            wrap_reg      <= '0;
            max_reg       <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= in_valid && emit;
            if (step)
            begin
                mode_reg  <= mode_next;
                bin_reg   <= bin_next;
                oct_reg   <= oct_next;
                dec_reg   <= dec_next;
                hex_reg   <= hex_next;
                wrap_reg  <= wrap_next;
                max_reg   <= max_next;
                held_reg  <= held_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (mode_reg == M_IDLE))
        else $error("scan not idle after result word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LINE_CHARS))
        else $error("character count past line limit");

    a_max_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg <= MAX_FOLDED)
        else $error("largest digit out of range");

    a_failed_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status != ST_OK)) |->
        ((result_reg.value == '0) && (result_reg.consumed == '0) && !result_reg.overflow))
        else $error("failed result word carries data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !advance) |=> (out_valid_reg && $stable(result_reg)))
        else $error("result word lost under stall");

endmodule
